// File: hdl/awvn_pkg.sv
// Shared types and constants for the area-weighted vertex normal accumulator.
// Holds the request and result structs, opcode codes and datapath widths.
// Depends on nothing.
package awvn_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_BITS      = 10;
    localparam int ADDR_BITS     = $clog2(TABLE_ENTRIES);
    localparam int POS_BITS      = 16;
    localparam int COORD_BITS    = 16;
    localparam int ACC_BITS      = 40;
    localparam int ENTRY_W       = 3 * ACC_BITS;
    localparam int DIFF_W        = COORD_BITS + 1;
    localparam int PROD_W        = 2 * DIFF_W;
    localparam int CROSS_W       = PROD_W + 1;
    localparam int UNIT_BITS     = 16;
    localparam int MAG_KEEP      = 30;
    localparam int SQ_W          = 64;
    localparam int DIV_W         = 48;
    localparam int Q_BITS        = 16;
    localparam int FRAC_SHIFT    = 15;

    localparam logic [1:0] OP_ACCUM = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [Q_BITS-1:0] UNIT_ONE = Q_BITS'(16384);

    typedef struct packed {
        logic [1:0]                 opcode;
        logic signed [POS_BITS-1:0] pos_x;
        logic signed [POS_BITS-1:0] pos_y;
        logic signed [POS_BITS-1:0] pos_z;
        logic [IDX_BITS-1:0]        table_index;
    } req_t;

    typedef struct packed {
        logic signed [UNIT_BITS-1:0] unit_x;
        logic signed [UNIT_BITS-1:0] unit_y;
        logic signed [UNIT_BITS-1:0] unit_z;
        logic                        zero_length;
    } result_t;

endpackage

// File: hdl/area_weighted_vertex_normals.sv
//  channel   direction  handshake                     payload
//  request   in         start high and busy low       req (req_t)
//  result    out        result_valid, one cycle       result (result_t)
//
// Corners one and two of a triangle are stored without leaving idle. The third
// corner runs the cross product (difference, multiply, sum), then a read and a
// write-back per corner through the single accumulator memory. A clear zeroes
// its entry in a single state. A read runs the serial range shift, the 32-step
// square root and three 16-step divisions; a read of an all-zero entry ends after
// the maximum search. After reset the block zeroes all 1024 table entries with
// busy high. Results cannot be stalled by the receiver.
// Top level of the accumulator; depends on awvn_pkg, awvn_ram and awvn_norm.
module area_weighted_vertex_normals
    import awvn_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  req_t    req,
    output logic    result_valid,
    output result_t result
);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DIFF, S_MUL, S_SUM, S_ACC_RD, S_ACC_WR, S_CLR,
        S_RD_ADDR, S_RD_DATA, S_NORM
    } state_t;

    state_t                     state_reg;
    logic [ADDR_BITS:0]         init_cnt_reg;
    logic [1:0]                 corner_cnt_reg;
    logic signed [COORD_BITS-1:0] pos_reg [3][3];
    logic [IDX_BITS-1:0]        idx_reg [3];
    logic [IDX_BITS-1:0]        op_idx_reg;
    logic signed [DIFF_W-1:0]   e1_reg [3];
    logic signed [DIFF_W-1:0]   e2_reg [3];
    logic signed [PROD_W-1:0]   prod_reg [6];
    logic signed [CROSS_W-1:0]  cross_reg [3];
    logic [1:0]                 acc_sel_reg;
    logic                       result_valid_reg;
    result_t                    result_reg;

    logic                       accept;
    logic                       ram_we;
    logic [ADDR_BITS-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]         ram_wdata;
    logic [ADDR_BITS-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]         ram_rdata;
    logic [ENTRY_W-1:0]         sat_entry;
    logic                       norm_start;
    logic                       norm_done;
    result_t                    norm_result;
    logic [IDX_BITS-1:0]        acc_idx;
    logic                       acc_in_table;
    logic                       op_in_table;
    logic                       req_in_table;
    logic signed [COORD_BITS-1:0] in_coord [3];

    assign accept       = start && !busy;
    assign busy         = state_reg != S_IDLE;
    assign acc_idx      = idx_reg[acc_sel_reg];
    assign acc_in_table = 17'(acc_idx) < 17'(TABLE_ENTRIES);
    assign op_in_table  = 17'(op_idx_reg) < 17'(TABLE_ENTRIES);
    assign req_in_table = 17'(req.table_index) < 17'(TABLE_ENTRIES);
    assign in_coord[0]  = req.pos_x[COORD_BITS-1:0];
    assign in_coord[1]  = req.pos_y[COORD_BITS-1:0];
    assign in_coord[2]  = req.pos_z[COORD_BITS-1:0];
    assign norm_start   = state_reg == S_RD_DATA;

    always_comb
    begin
        logic signed [ACC_BITS:0] sum;
        for (int a = 0; a < 3; a++)
        begin
            sum = (ACC_BITS+1)'($signed(ram_rdata[a*ACC_BITS +: ACC_BITS]))
                + (ACC_BITS+1)'(cross_reg[a]);
            if (sum[ACC_BITS] != sum[ACC_BITS-1])
            begin
                sat_entry[a*ACC_BITS +: ACC_BITS] =
                    {sum[ACC_BITS], {(ACC_BITS-1){~sum[ACC_BITS]}}};
            end
            else
            begin
                sat_entry[a*ACC_BITS +: ACC_BITS] = sum[ACC_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = acc_idx[ADDR_BITS-1:0];
        ram_wdata = sat_entry;
        ram_raddr = acc_idx[ADDR_BITS-1:0];
        case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = init_cnt_reg[ADDR_BITS-1:0];
                ram_wdata = '0;
            end
            S_ACC_WR:
            begin
                ram_we = acc_in_table;
            end
            S_CLR:
            begin
                ram_we    = op_in_table;
                ram_waddr = op_idx_reg[ADDR_BITS-1:0];
                ram_wdata = '0;
            end
            S_RD_ADDR:
            begin
                ram_raddr = op_idx_reg[ADDR_BITS-1:0];
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_INIT;
            init_cnt_reg     <= '0;
            corner_cnt_reg   <= '0;
            op_idx_reg       <= '0;
            acc_sel_reg      <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
            for (int c = 0; c < 3; c++)
            begin
                idx_reg[c]   <= '0;
                e1_reg[c]    <= '0;
                e2_reg[c]    <= '0;
                cross_reg[c] <= '0;
                for (int a = 0; a < 3; a++)
                begin
                    pos_reg[c][a] <= '0;
                end
            end
            for (int p = 0; p < 6; p++)
            begin
                prod_reg[p] <= '0;
            end
        end
        else
        begin
            result_valid_reg <= 1'b0;
            case (state_reg)
                S_INIT:
                begin
                    init_cnt_reg <= init_cnt_reg + 1'b1;
                    if (init_cnt_reg == (ADDR_BITS+1)'(TABLE_ENTRIES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_idx_reg <= req.table_index;
                        case (req.opcode)
                            OP_ACCUM:
                            begin
                                for (int a = 0; a < 3; a++)
                                begin
                                    pos_reg[corner_cnt_reg][a] <= in_coord[a];
                                end
                                idx_reg[corner_cnt_reg] <= req.table_index;
                                if (corner_cnt_reg == 2'd2)
                                begin
                                    corner_cnt_reg <= '0;
                                    state_reg      <= S_DIFF;
                                end
                                else
                                begin
                                    corner_cnt_reg <= corner_cnt_reg + 1'b1;
                                end
                            end
                            OP_READ:
                            begin
                                if (req_in_table)
                                begin
                                    state_reg <= S_RD_ADDR;
                                end
                                else
                                begin
                                    result_reg       <= '{unit_x: '0, unit_y: '0,
                                                          unit_z: '0, zero_length: 1'b1};
                                    result_valid_reg <= 1'b1;
                                end
                            end
                            OP_CLEAR:
                            begin
                                state_reg <= S_CLR;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_DIFF:
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        e1_reg[a] <= DIFF_W'(pos_reg[1][a]) - DIFF_W'(pos_reg[0][a]);
                        e2_reg[a] <= DIFF_W'(pos_reg[2][a]) - DIFF_W'(pos_reg[0][a]);
                    end
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    prod_reg[0] <= e1_reg[1] * e2_reg[2];
                    prod_reg[1] <= e1_reg[2] * e2_reg[1];
                    prod_reg[2] <= e1_reg[2] * e2_reg[0];
                    prod_reg[3] <= e1_reg[0] * e2_reg[2];
                    prod_reg[4] <= e1_reg[0] * e2_reg[1];
                    prod_reg[5] <= e1_reg[1] * e2_reg[0];
                    state_reg   <= S_SUM;
                end
                S_SUM:
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        cross_reg[a] <= CROSS_W'(prod_reg[2*a]) - CROSS_W'(prod_reg[2*a+1]);
                    end
                    acc_sel_reg <= '0;
                    state_reg   <= S_ACC_RD;
                end
                S_ACC_RD:
                begin
                    state_reg <= S_ACC_WR;
                end
                S_ACC_WR:
                begin
                    if (acc_sel_reg == 2'd2)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        acc_sel_reg <= acc_sel_reg + 1'b1;
                        state_reg   <= S_ACC_RD;
                    end
                end
                S_CLR:
                begin
                    state_reg <= S_IDLE;
                end
                S_RD_ADDR:
                begin
                    state_reg <= S_RD_DATA;
                end
                S_RD_DATA:
                begin
                    state_reg <= S_NORM;
                end
                S_NORM:
                begin
                    if (norm_done)
                    begin
                        result_reg       <= norm_result;
                        result_valid_reg <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    awvn_ram #(
        .DATA_W (ENTRY_W),
        .ADDR_W (ADDR_BITS),
        .DEPTH  (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    awvn_norm u_norm (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (norm_start),
        .entry  (ram_rdata),
        .done   (norm_done),
        .result (norm_result)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The table is only written by the clearing pass, a clear or a write-back.
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !ram_we)
        else $error("accumulator memory written while idle");

    // One request yields at most one result, so results never come back to back.
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |=> !result_valid_reg)
        else $error("two results in consecutive cycles");

    // A third corner always starts the triangle sequence.
    a_third_corner: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.opcode == OP_ACCUM && corner_cnt_reg == 2'd2 |=> state_reg == S_DIFF)
        else $error("third corner did not start accumulation");

    // A normalized result is only captured while a read is in progress.
    a_norm_done_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        norm_done |-> state_reg == S_NORM)
        else $error("normalizer finished outside a read");

endmodule

// File: hdl/awvn_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module awvn_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4,
    parameter int DEPTH  = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/awvn_norm.sv
// Multi-cycle normalizer: scales one accumulator entry to unit length in Q1.14.
// Uses a serial range shift, a bit-serial square root and a shared serial divider.
// Depends on awvn_pkg.
module awvn_norm
    import awvn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [ENTRY_W-1:0] entry,
    output logic               done,
    output result_t            result
);

    typedef enum logic [3:0] {
        N_IDLE, N_MAX, N_SHIFT, N_SQ, N_SUM, N_SQRT, N_LEN, N_DIVINIT, N_DIV, N_STORE
    } nstate_t;

    nstate_t               state_reg;
    logic [2:0]            neg_reg;
    logic [ACC_BITS-1:0]   mag_reg [3];
    logic [ACC_BITS-1:0]   mx_reg;
    logic [2*MAG_KEEP-1:0] sq_reg [3];
    logic [SQ_W-1:0]       s_reg;
    logic [SQ_W-1:0]       r_reg;
    logic [SQ_W-1:0]       bit_reg;
    logic [DIV_W-1:0]      num_reg;
    logic [DIV_W-1:0]      dsh_reg;
    logic [Q_BITS-1:0]     q_reg;
    logic [3:0]            cnt_reg;
    logic [1:0]            comp_reg;
    logic [UNIT_BITS-1:0]  unit_reg [3];
    logic                  zero_reg;
    logic                  done_reg;

    logic [ACC_BITS-1:0]   max01;
    logic [ACC_BITS-1:0]   max012;
    logic [SQ_W-1:0]       rb;
    logic                  sq_ge;
    logic                  div_ge;
    logic [Q_BITS-1:0]     q_cap;
    logic [UNIT_BITS-1:0]  q_signed;

    assign max01    = (mag_reg[1] > mag_reg[0]) ? mag_reg[1] : mag_reg[0];
    assign max012   = (mag_reg[2] > max01) ? mag_reg[2] : max01;
    assign rb       = r_reg + bit_reg;
    assign sq_ge    = s_reg >= rb;
    assign div_ge   = num_reg >= dsh_reg;
    assign q_cap    = (q_reg > UNIT_ONE) ? UNIT_ONE : q_reg;
    assign q_signed = neg_reg[comp_reg] ? UNIT_BITS'(-q_cap) : UNIT_BITS'(q_cap);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
            zero_reg  <= 1'b1;
            neg_reg   <= '0;
            mx_reg    <= '0;
            s_reg     <= '0;
            r_reg     <= '0;
            bit_reg   <= '0;
            num_reg   <= '0;
            dsh_reg   <= '0;
            q_reg     <= '0;
            cnt_reg   <= '0;
            comp_reg  <= '0;
            for (int a = 0; a < 3; a++)
            begin
                mag_reg[a]  <= '0;
                sq_reg[a]   <= '0;
                unit_reg[a] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                N_IDLE:
                begin
                    if (start)
                    begin
                        for (int a = 0; a < 3; a++)
                        begin
                            neg_reg[a] <= entry[a*ACC_BITS + ACC_BITS - 1];
                            mag_reg[a] <= entry[a*ACC_BITS + ACC_BITS - 1]
                                        ? (~entry[a*ACC_BITS +: ACC_BITS] + 1'b1)
                                        : entry[a*ACC_BITS +: ACC_BITS];
                        end
                        state_reg <= N_MAX;
                    end
                end
                N_MAX:
                begin
                    mx_reg <= max012;
                    if (max012 == '0)
                    begin
                        for (int a = 0; a < 3; a++)
                        begin
                            unit_reg[a] <= '0;
                        end
                        zero_reg  <= 1'b1;
                        done_reg  <= 1'b1;
                        state_reg <= N_IDLE;
                    end
                    else
                    begin
                        state_reg <= N_SHIFT;
                    end
                end
                N_SHIFT:
                begin
                    if (|mx_reg[ACC_BITS-1:MAG_KEEP])
                    begin
                        mx_reg <= mx_reg >> 1;
                        for (int a = 0; a < 3; a++)
                        begin
                            mag_reg[a] <= mag_reg[a] >> 1;
                        end
                    end
                    else
                    begin
                        state_reg <= N_SQ;
                    end
                end
                N_SQ:
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        sq_reg[a] <= mag_reg[a][MAG_KEEP-1:0] * mag_reg[a][MAG_KEEP-1:0];
                    end
                    state_reg <= N_SUM;
                end
                N_SUM:
                begin
                    s_reg     <= SQ_W'(sq_reg[0]) + SQ_W'(sq_reg[1]) + SQ_W'(sq_reg[2]);
                    r_reg     <= '0;
                    bit_reg   <= SQ_W'(1) << (SQ_W - 2);
                    state_reg <= N_SQRT;
                end
                N_SQRT:
                begin
                    if (sq_ge)
                    begin
                        s_reg <= s_reg - rb;
                        r_reg <= (r_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        r_reg <= r_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0])
                    begin
                        state_reg <= N_LEN;
                    end
                end
                N_LEN:
                begin
                    comp_reg <= '0;
                    if (r_reg == '0)
                    begin
                        for (int a = 0; a < 3; a++)
                        begin
                            unit_reg[a] <= '0;
                        end
                        zero_reg  <= 1'b1;
                        done_reg  <= 1'b1;
                        state_reg <= N_IDLE;
                    end
                    else
                    begin
                        state_reg <= N_DIVINIT;
                    end
                end
                N_DIVINIT:
                begin
                    num_reg   <= (DIV_W'(mag_reg[comp_reg][MAG_KEEP-1:0]) << FRAC_SHIFT)
                               + DIV_W'(r_reg[31:0]);
                    dsh_reg   <= DIV_W'(r_reg[31:0]) << (FRAC_SHIFT + 1);
                    q_reg     <= '0;
                    cnt_reg   <= 4'(Q_BITS - 1);
                    state_reg <= N_DIV;
                end
                N_DIV:
                begin
                    if (div_ge)
                    begin
                        num_reg <= num_reg - dsh_reg;
                    end
                    q_reg   <= {q_reg[Q_BITS-2:0], div_ge};
                    dsh_reg <= dsh_reg >> 1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= N_STORE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                N_STORE:
                begin
                    unit_reg[comp_reg] <= q_signed;
                    if (comp_reg == 2'd2)
                    begin
                        zero_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                        state_reg <= N_IDLE;
                    end
                    else
                    begin
                        comp_reg  <= comp_reg + 1'b1;
                        state_reg <= N_DIVINIT;
                    end
                end
                default:
                begin
                    state_reg <= N_IDLE;
                end
            endcase
        end
    end

    assign done               = done_reg;
    assign result.unit_x      = unit_reg[0];
    assign result.unit_y      = unit_reg[1];
    assign result.unit_z      = unit_reg[2];
    assign result.zero_length = zero_reg;

endmodule

// File: bench/tb_area_weighted_vertex_normals.sv
// Testbench for the area-weighted vertex normal accumulator.
// Drives corner, read and clear requests and checks each read result against a predictor.
// Depends on awvn_pkg and area_weighted_vertex_normals.
module tb_area_weighted_vertex_normals;
    import awvn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SUM_MAX = (64'sd1 <<< (ACC_BITS - 1)) - 1;
    localparam longint SUM_MIN = -(64'sd1 <<< (ACC_BITS - 1));
    localparam int CYCLE_LIMIT = 1500000;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    req_t    req;
    logic    result_valid;
    result_t result;

    longint  sums [TABLE_ENTRIES][3];
    longint  held_pos [3][3];
    int      held_idx [3];
    int      held_count;
    result_t normals_due [$];
    int      mismatches;
    int      cycles;
    bit      no_gaps;

    area_weighted_vertex_normals dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req(req), .result_valid(result_valid), .result(result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint clamp_sum(longint v);
        if (v > SUM_MAX) return SUM_MAX;
        if (v < SUM_MIN) return SUM_MIN;
        return v;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic result_t unit_of_entry(int idx);
        result_t o;
        longint unsigned m [3];
        longint unsigned mx, len, q;
        int k;
        o = '0;
        o.zero_length = 1'b1;
        if (idx >= TABLE_ENTRIES) return o;
        for (int a = 0; a < 3; a++)
            m[a] = sums[idx][a] < 0 ? -sums[idx][a] : sums[idx][a];
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        if (mx == 0) return o;
        k = 0;
        while ((mx >> k) >= (64'd1 << MAG_KEEP)) k++;
        for (int a = 0; a < 3; a++) m[a] = m[a] >> k;
        len = root_floor(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        if (len == 0) return o;
        o.zero_length = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            q = (2 * (m[a] << 14) + len) / (2 * len);
            if (q > 16384) q = 16384;
            if (sums[idx][a] < 0) q = -q;
            if (a == 0) o.unit_x = q[15:0];
            else if (a == 1) o.unit_y = q[15:0];
            else o.unit_z = q[15:0];
        end
        return o;
    endfunction

    task automatic predict_request(req_t r);
        longint e1 [3], e2 [3], n [3];
        if (r.opcode == OP_ACCUM)
        begin
            held_pos[held_count][0] = r.pos_x;
            held_pos[held_count][1] = r.pos_y;
            held_pos[held_count][2] = r.pos_z;
            held_idx[held_count] = r.table_index;
            if (held_count == 2)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    e1[a] = held_pos[1][a] - held_pos[0][a];
                    e2[a] = held_pos[2][a] - held_pos[0][a];
                end
                n[0] = e1[1] * e2[2] - e1[2] * e2[1];
                n[1] = e1[2] * e2[0] - e1[0] * e2[2];
                n[2] = e1[0] * e2[1] - e1[1] * e2[0];
                for (int c = 0; c < 3; c++)
                    if (held_idx[c] < TABLE_ENTRIES)
                        for (int a = 0; a < 3; a++)
                            sums[held_idx[c]][a] = clamp_sum(sums[held_idx[c]][a] + n[a]);
                held_count = 0;
            end
            else
                held_count++;
        end
        else if (r.opcode == OP_READ)
            normals_due = {normals_due, unit_of_entry(r.table_index)};
        else if (r.opcode == OP_CLEAR && r.table_index < TABLE_ENTRIES)
            for (int a = 0; a < 3; a++) sums[r.table_index][a] = 0;
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    task automatic send_request(req_t r);
        if (!no_gaps)
            while ($urandom_range(99) < 29)
            begin
                start <= 1'b0;
                req <= req_t'($urandom);
                @(posedge clk);
            end
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_request(r);
    endtask

    function automatic req_t make_req(logic [1:0] op, int x, int y, int z, int idx);
        req_t r;
        r.opcode = op;
        r.pos_x = x[15:0];
        r.pos_y = y[15:0];
        r.pos_z = z[15:0];
        r.table_index = idx[9:0];
        return r;
    endfunction

    function automatic int pick_coord();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? 32767 : -32768;
            1: return $signed(16'($urandom));
            default: return int'($urandom_range(2047)) - 1024;
        endcase
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout");
                $display("tb_area_weighted_vertex_normals failed");
                $finish;
            end
            if (result_valid)
            begin
                if (normals_due.size() == 0)
                    report_mismatch("unexpected result", 1, 0);
                else
                begin
                    want = normals_due.pop_front();
                    if (result.unit_x !== want.unit_x)
                        report_mismatch("unit_x", result.unit_x, want.unit_x);
                    if (result.unit_y !== want.unit_y)
                        report_mismatch("unit_y", result.unit_y, want.unit_y);
                    if (result.unit_z !== want.unit_z)
                        report_mismatch("unit_z", result.unit_z, want.unit_z);
                    if (result.zero_length !== want.zero_length)
                        report_mismatch("zero_length", result.zero_length, want.zero_length);
                end
            end
        end
    end

    task automatic test_directed();
        send_request(make_req(OP_READ, 0, 0, 0, 0));
        send_request(make_req(OP_READ, 0, 0, 0, 1023));
        send_request(make_req(OP_ACCUM, -32768, -32768, -32768, 0));
        send_request(make_req(OP_ACCUM, 32767, -32768, 32767, 1023));
        send_request(make_req(OP_ACCUM, -32768, 32767, 32767, 5));
        send_request(make_req(OP_READ, 0, 0, 0, 0));
        send_request(make_req(OP_READ, 0, 0, 0, 1023));
        send_request(make_req(OP_ACCUM, 0, 0, 0, 7));
        send_request(make_req(OP_ACCUM, 256, 256, 256, 7));
        send_request(make_req(OP_ACCUM, 512, 512, 512, 8));
        send_request(make_req(OP_READ, 0, 0, 0, 7));
        send_request(make_req(OP_ACCUM, 0, 0, 0, 9));
        send_request(make_req(OP_ACCUM, 256, 0, 0, 9));
        send_request(make_req(OP_ACCUM, 0, 256, 0, 10));
        send_request(make_req(OP_READ, 0, 0, 0, 9));
        send_request(make_req(OP_CLEAR, 0, 0, 0, 9));
        send_request(make_req(OP_READ, 0, 0, 0, 9));
        send_request(make_req(2'd3, -1, -1, -1, 10));
        send_request(make_req(OP_READ, 0, 0, 0, 10));
        send_request(make_req(OP_CLEAR, -1, -1, -1, 1023));
        send_request(make_req(OP_READ, 0, 0, 0, 1023));
    endtask

    task automatic test_saturation();
        for (int t = 0; t < 40; t++)
        begin
            send_request(make_req(OP_ACCUM, -32768, -32768, 0, 3));
            send_request(make_req(OP_ACCUM, 32767, -32768, 32767, 3));
            send_request(make_req(OP_ACCUM, -32768, 32767, -32768, 4));
        end
        send_request(make_req(OP_READ, 0, 0, 0, 3));
        send_request(make_req(OP_READ, 0, 0, 0, 4));
    endtask

    task automatic test_random_mesh();
        int idx;
        for (int t = 0; t < 910; t++)
        begin
            no_gaps = (t >= 400 && t < 550);
            idx = $urandom_range(1) ? $urandom_range(15) : $urandom_range(1023);
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5:
                    send_request(make_req(OP_ACCUM, pick_coord(), pick_coord(),
                                          pick_coord(), idx));
                6, 7:
                    send_request(make_req(OP_READ, pick_coord(), 0, 0, idx));
                8:
                    send_request(make_req(OP_CLEAR, pick_coord(), 0, 0, idx));
                default:
                    send_request(make_req(2'd3, pick_coord(), pick_coord(),
                                          pick_coord(), idx));
            endcase
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        int waited;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            for (int a = 0; a < 3; a++) sums[i][a] = 0;
        held_count = 0;
        mismatches = 0;
        cycles = 0;
        no_gaps = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_saturation();
        test_random_mesh();
        start <= 1'b0;
        waited = 0;
        while (normals_due.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (200) @(posedge clk);
        if (normals_due.size() != 0)
            report_mismatch("results outstanding", 0, normals_due.size());
        if (mismatches == 0)
            $display("tb_area_weighted_vertex_normals passed");
        else
            $display("tb_area_weighted_vertex_normals failed");
        $finish;
    end
endmodule

// File: sim.f
hdl/awvn_pkg.sv
hdl/awvn_ram.sv
hdl/awvn_norm.sv
hdl/area_weighted_vertex_normals.sv
bench/tb_area_weighted_vertex_normals.sv
